>>> rtl/hps_pkg.sv
// ----------------------------------------------------------------------------
// hps_pkg
// Shared types, codes and constants of the hyperparameter schedule block.
// ----------------------------------------------------------------------------
package hps_pkg;

  localparam int VW       = 32;  // value width, unsigned Q8.(VW-8)
  localparam int SW       = 32;  // step count width
  localparam int NUM_W    = 64;  // divider dividend / quotient width
  localparam int DEN_W    = SW + 1;
  localparam int CNT_W    = $clog2(NUM_W);
  localparam int FRAC_W   = 16;  // exponential fraction bits
  localparam int FK_W     = $clog2(FRAC_W);
  localparam int CFG_IX_W = 3;

  typedef enum logic [1:0] {
    MODE_FIXED  = 2'd0,
    MODE_LINEAR = 2'd1,
    MODE_EXP    = 2'd2,
    MODE_INV    = 2'd3
  } mode_t;

  typedef enum logic [CFG_IX_W-1:0] {
    CFG_MODE   = 3'd0,
    CFG_PERIOD = 3'd1,
    CFG_BASE   = 3'd2,
    CFG_FINAL  = 3'd3,
    CFG_TOTAL  = 3'd4
  } cfg_ix_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_POST,
    BK_POW,
    BK_FIN
  } bk_state_t;

  // classified request passed from front to back
  typedef struct packed {
    logic [SW-1:0] step;
    logic          finished;
    logic          derr;
    mode_t         mode;
  } sched_req_t;

  // queue status seen by the front, the back and the top
  typedef struct packed {
    logic       full;
    logic       empty;
    logic [1:0] count;
  } q_stat_t;

  // truncated integer square root, used only at elaboration
  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bt;
    logic [63:0] xv;
    res = '0;
    bt  = 64'h4000_0000_0000_0000;
    xv  = x;
    for (int i = 0; i < 32; i++) begin
      if (xv >= res + bt) begin
        xv  = xv - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // factor 2^(-2^(k-16)) in Q0.32 for fraction bit k
  function automatic logic [31:0] exp_fact(input int k);
    logic [63:0] c;
    c = isqrt64(64'h8000_0000_0000_0000);
    for (int j = 0; j < 15 - k; j++) begin
      c = isqrt64({c[31:0], 32'h0});
    end
    return c[31:0];
  endfunction

  localparam logic [31:0] EXP_FACT [FRAC_W] = '{
    exp_fact(0),  exp_fact(1),  exp_fact(2),  exp_fact(3),
    exp_fact(4),  exp_fact(5),  exp_fact(6),  exp_fact(7),
    exp_fact(8),  exp_fact(9),  exp_fact(10), exp_fact(11),
    exp_fact(12), exp_fact(13), exp_fact(14), exp_fact(15)
  };

endpackage

>>> rtl/hps_front.sv
// ----------------------------------------------------------------------------
// hps_front
// Accepts requests, keeps the step counter and classifies each request.
// ----------------------------------------------------------------------------
module hps_front import hps_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_advance,
  input  mode_t            mode,
  input  logic [SW-1:0]    period,
  input  logic [SW-1:0]    total,
  input  q_stat_t          q_stat,
  output logic             push,
  output sched_req_t       push_req
);

  logic [SW-1:0] step_r, step_nxt;

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  // classify against current config
  always_comb begin
    push_req.step     = step_r;
    push_req.finished = (step_r >= total);
    push_req.derr     = (mode != MODE_FIXED) && (period == '0);
    push_req.mode     = mode;
  end

  // step counter, saturating
  always_comb begin
    step_nxt = step_r;
    if (push && in_advance && (step_r != {SW{1'b1}})) begin
      step_nxt = step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

>>> rtl/hps_queue.sv
// ----------------------------------------------------------------------------
// hps_queue
// Two-entry request queue between front and back.
// ----------------------------------------------------------------------------
module hps_queue import hps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  sched_req_t push_req,
  input  logic       pop,
  output sched_req_t pop_req,
  output q_stat_t    q_stat
);

  sched_req_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign pop_req      = mem_r[rp_r];
  assign q_stat.count = cnt_r;
  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_req;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> rtl/hps_back.sv
// ----------------------------------------------------------------------------
// hps_back
// Computes the scheduled value with one shared multiplier and a radix-2
// restoring divider, and holds the result in the output register.
// ----------------------------------------------------------------------------
module hps_back import hps_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  q_stat_t          q_stat,
  input  sched_req_t       pop_req,
  output logic             pop,
  input  logic [SW-1:0]    period,
  input  logic [VW-1:0]    base,
  input  logic [VW-1:0]    fin,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [VW-1:0]    out_scheduled_value,
  output logic [SW-1:0]    out_current_step,
  output logic             out_finished,
  output logic             out_divide_error
);

  bk_state_t         st_r, st_nxt;
  sched_req_t        req_r, req_nxt;
  logic              up_r, up_nxt;      // linear: final >= base
  logic              ph2_r, ph2_nxt;    // exponential: second division
  logic [31:0]       ma_r, ma_nxt;      // multiplier operand A
  logic [31:0]       mb_r, mb_nxt;      // multiplier operand B
  logic [NUM_W-1:0]  num_r, num_nxt;    // dividend, then quotient
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [VW-1:0]     v_r, v_nxt;        // shifted base
  logic [32:0]       m_r, m_nxt;        // fractional power, Q1.32
  logic [FRAC_W-1:0] f_r, f_nxt;
  logic [FK_W-1:0]   k_r, k_nxt;
  logic              ov_r, ov_nxt;
  logic [VW-1:0]     oval_r, oval_nxt;
  sched_req_t        oreq_r, oreq_nxt;

  logic [32:0]       mul_a;
  logic [31:0]       mul_b;
  logic [64:0]       prod;
  logic [DEN_W:0]    rem_sh;
  logic              qbit;
  logic [NUM_W-1:0]  lim;

  assign out_valid           = ov_r;
  assign out_scheduled_value = oval_r;
  assign out_current_step    = oreq_r.step;
  assign out_finished        = oreq_r.finished;
  assign out_divide_error    = oreq_r.derr;

  // shared multiplier
  always_comb begin
    mul_a = {1'b0, ma_r};
    mul_b = mb_r;
    case (st_r)
      BK_POW:  begin mul_a = m_r; mul_b = EXP_FACT[k_r]; end
      BK_FIN:  begin mul_a = m_r; mul_b = v_r;           end
      default: begin mul_a = {1'b0, ma_r}; mul_b = mb_r; end
    endcase
    prod = mul_a * {1'b0, mul_b};
  end

  // one divider step
  always_comb begin
    rem_sh = {rem_r, num_r[NUM_W-1]};
    qbit   = (rem_sh >= {1'b0, den_r});
  end

  assign lim = {{(NUM_W-VW){1'b0}}, ~base};

  // sequencer
  always_comb begin
    st_nxt   = st_r;
    req_nxt  = req_r;
    up_nxt   = up_r;
    ph2_nxt  = ph2_r;
    ma_nxt   = ma_r;
    mb_nxt   = mb_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    v_nxt    = v_r;
    m_nxt    = m_r;
    f_nxt    = f_r;
    k_nxt    = k_r;
    ov_nxt   = ov_r && out_stall;
    oval_nxt = oval_r;
    oreq_nxt = oreq_r;
    pop      = 1'b0;
    case (st_r)
      BK_IDLE: begin
        if (!q_stat.empty && !ov_r) begin
          pop     = 1'b1;
          req_nxt = pop_req;
          up_nxt  = (fin >= base);
          ph2_nxt = 1'b0;
          rem_nxt = '0;
          cnt_nxt = '0;
          if (pop_req.derr || pop_req.mode == MODE_FIXED) begin
            ov_nxt   = 1'b1;
            oval_nxt = base;
            oreq_nxt = pop_req;
          end else begin
            case (pop_req.mode)
              MODE_LINEAR: begin
                ma_nxt  = (fin >= base) ? (fin - base) : (base - fin);
                mb_nxt  = pop_req.step;
                den_nxt = {1'b0, period};
                st_nxt  = BK_MUL;
              end
              MODE_INV: begin
                ma_nxt  = base;
                mb_nxt  = period;
                den_nxt = {1'b0, period} + {1'b0, pop_req.step};
                st_nxt  = BK_MUL;
              end
              default: begin
                num_nxt = {{(NUM_W-SW){1'b0}}, pop_req.step};
                den_nxt = {1'b0, period};
                st_nxt  = BK_DIV;
              end
            endcase
          end
        end
      end
      BK_MUL: begin
        num_nxt = prod[NUM_W-1:0];
        st_nxt  = BK_DIV;
      end
      BK_DIV: begin
        rem_nxt = qbit ? (rem_sh[DEN_W-1:0] - den_r) : rem_sh[DEN_W-1:0];
        num_nxt = {num_r[NUM_W-2:0], qbit};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == {CNT_W{1'b1}}) st_nxt = BK_POST;
      end
      BK_POST: begin
        case (req_r.mode)
          MODE_LINEAR: begin
            if (up_r) begin
              oval_nxt = (num_r > lim) ? {VW{1'b1}} : base + num_r[VW-1:0];
            end else begin
              oval_nxt = (num_r >= {{(NUM_W-VW){1'b0}}, base}) ? '0
                                                               : base - num_r[VW-1:0];
            end
            ov_nxt   = 1'b1;
            oreq_nxt = req_r;
            st_nxt   = BK_IDLE;
          end
          MODE_INV: begin
            oval_nxt = num_r[VW-1:0];
            ov_nxt   = 1'b1;
            oreq_nxt = req_r;
            st_nxt   = BK_IDLE;
          end
          default: begin
            if (!ph2_r) begin
              // integer part sets the shift, remainder feeds the fraction
              if (num_r >= NUM_W'(VW)) begin
                oval_nxt = '0;
                ov_nxt   = 1'b1;
                oreq_nxt = req_r;
                st_nxt   = BK_IDLE;
              end else begin
                v_nxt   = base >> num_r[CNT_W-1:0];
                num_nxt = {{(NUM_W-SW-FRAC_W){1'b0}}, rem_r[SW-1:0], {FRAC_W{1'b0}}};
                rem_nxt = '0;
                cnt_nxt = '0;
                ph2_nxt = 1'b1;
                st_nxt  = BK_DIV;
              end
            end else begin
              f_nxt  = num_r[FRAC_W-1:0];
              m_nxt  = {1'b1, 32'h0};
              k_nxt  = {FK_W{1'b1}};
              st_nxt = BK_POW;
            end
          end
        endcase
      end
      BK_POW: begin
        if (f_r[k_r]) m_nxt = prod[64:32];
        k_nxt = k_r - 1'b1;
        if (k_r == '0) st_nxt = BK_FIN;
      end
      BK_FIN: begin
        oval_nxt = prod[32 +: VW];
        ov_nxt   = 1'b1;
        oreq_nxt = req_r;
        st_nxt   = BK_IDLE;
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    up_r   <= up_nxt;
    ph2_r  <= ph2_nxt;
    ma_r   <= ma_nxt;
    mb_r   <= mb_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    v_r    <= v_nxt;
    m_r    <= m_nxt;
    f_r    <= f_nxt;
    k_r    <= k_nxt;
    oval_r <= oval_nxt;
    oreq_r <= oreq_nxt;
  end

endmodule

>>> rtl/hyperparameter_schedule.sv
// ----------------------------------------------------------------------------
// hyperparameter_schedule
// Per-step value schedule (fixed, linear, exponential halving, inverse time).
// ----------------------------------------------------------------------------
//   channel   direction  handshake             payload
//   in_       input      in_valid / in_stall    in_advance
//   out_      output     out_valid / out_stall  value, step, finished, error
//   cfg_      input      cfg_we                 cfg_index, cfg_wdata
//
// Fixed mode and zero period: the back loads base into the output register from idle.
// Linear and inverse time: a multiply, then a 64-step divider.
// Exponential: two 64-step divisions, then 16 power steps.
// The front takes up to two requests while the back is busy or stalled.
// Reset is synchronous, active low; it clears the step count and config (period resets to 1).
module hyperparameter_schedule import hps_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_advance,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [VW-1:0]       out_scheduled_value,
  output logic [SW-1:0]       out_current_step,
  output logic                out_finished,
  output logic                out_divide_error,
  input  logic                cfg_we,
  input  logic [CFG_IX_W-1:0] cfg_index,
  input  logic [31:0]         cfg_wdata
);

  mode_t         mode_r;
  logic [SW-1:0] period_r;
  logic [VW-1:0] base_r;
  logic [VW-1:0] final_r;
  logic [SW-1:0] total_r;

  q_stat_t       q_stat;
  logic          push, pop;
  sched_req_t    push_req, pop_req;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_FIXED;
      period_r <= SW'(1);
      base_r   <= '0;
      final_r  <= '0;
      total_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:   mode_r   <= mode_t'(cfg_wdata[1:0]);
        CFG_PERIOD: period_r <= cfg_wdata[SW-1:0];
        CFG_BASE:   base_r   <= cfg_wdata[VW-1:0];
        CFG_FINAL:  final_r  <= cfg_wdata[VW-1:0];
        CFG_TOTAL:  total_r  <= cfg_wdata[SW-1:0];
        default:    ;
      endcase
    end
  end

  hps_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_advance (in_advance),
    .mode       (mode_r),
    .period     (period_r),
    .total      (total_r),
    .q_stat     (q_stat),
    .push       (push),
    .push_req   (push_req)
  );

  hps_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .pop_req  (pop_req),
    .q_stat   (q_stat)
  );

  hps_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_stat              (q_stat),
    .pop_req             (pop_req),
    .pop                 (pop),
    .period              (period_r),
    .base                (base_r),
    .fin                 (final_r),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_scheduled_value (out_scheduled_value),
    .out_current_step    (out_current_step),
    .out_finished        (out_finished),
    .out_divide_error    (out_divide_error)
  );

`ifndef ASSERT_OFF
  // queue never holds more than two requests
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count != 2'd3)
    else $error("request queue overfilled");

  // a divide error always reports the base value
  a_derr_base: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_error |-> out_scheduled_value == base_r)
    else $error("divide error without base value");

  // finished flag agrees with the step limit
  a_finished: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_finished == (out_current_step >= total_r))
    else $error("finished flag mismatch");

  // fixed mode gives base and never flags
  a_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mode_r == MODE_FIXED |->
      !out_divide_error && out_scheduled_value == base_r)
    else $error("fixed mode result wrong");
`endif

endmodule
